// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignored while reset is high.
`define CSTA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property at every rising edge, reset included.
`define CSTA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: hw/rtl/csta_pkg.sv
package csta_pkg;

   localparam int DEFAULT_MAX_CLIENTS = 16;
   localparam int TIMEOUT_W           = 16;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd6000;

   localparam logic OP_MSG   = 1'b0;
   localparam logic OP_SWEEP = 1'b1;

   localparam logic [2:0] KIND_REFRESHED = 3'd0;
   localparam logic [2:0] KIND_ADDED     = 3'd1;
   localparam logic [2:0] KIND_FULL      = 3'd2;
   localparam logic [2:0] KIND_REMOVED   = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;

   typedef struct packed {
      logic        op;
      logic [7:0]  client_addr;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] result_addr;
      logic [3:0] slot;
      logic [4:0] active_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  addr;
      logic [31:0] seen;
   } entry_type;

   typedef struct packed {
      logic addr_hit;
      logic stale;
   } cmp_type;

endpackage

// File: hw/rtl/csta_cmp.sv
module csta_cmp (
   input  csta_pkg::entry_type              entry,
   input  logic [7:0]                       client_addr,
   input  logic [31:0]                      now_ms,
   input  logic [csta_pkg::TIMEOUT_W-1:0]   timeout_ms,
   output csta_pkg::cmp_type                result
);

   logic [31:0] age;

   // Age wraps modulo 2^32 along with the millisecond counter.
   assign age             = now_ms - entry.seen;
   assign result.stale    = (age > 32'(timeout_ms));
   assign result.addr_hit = (entry.addr == client_addr);

endmodule

// File: hw/rtl/csta_store.sv
module csta_store #(
   parameter int DEPTH = csta_pkg::DEFAULT_MAX_CLIENTS
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
   input  csta_pkg::entry_type                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
   output csta_pkg::entry_type                        rd_data
);

   csta_pkg::entry_type mem [DEPTH];
   csta_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/client_session_table_with_aging.sv
// Client session table with aging.
// req_*: one transaction per item (op, client_addr, now_ms); req_stall is high
//   while an item is being worked on, low when the block can take one.
// rsp_*: results (kind, result_addr, slot, active_count, last). A message
//   gives exactly one result; a sweep gives one result per removed client
//   and then a closing result with last high.
// csr_*: write of timeout_ms; csr_ready is always high.
// Walk: the table is walked one entry at a time, each entry passing a fetch
//   state and a check state, through a single registered-read memory port
//   and one shared compare unit. A message reads entries until one hits or
//   it reaches the end of the table; a sweep visits all N active clients.
//   Either walk can also wait on the result register. A new transaction is
//   accepted only after the walk of the current one has ended.
// The final result of an item sits in the output register while the next
//   item is accepted. When rsp_stall is high the result register holds,
//   and the walk pauses at the next result it must deliver.
// Reset (synchronous, active high) empties the table, drops any pending
//   result and reloads timeout_ms with 6000; no clearing pass is needed.
module client_session_table_with_aging #(
   parameter int MAX_CLIENTS = csta_pkg::DEFAULT_MAX_CLIENTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  csta_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output csta_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [csta_pkg::TIMEOUT_W-1:0]    csr_data
);

   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_CLIENTS);

   typedef enum logic [1:0] {S_IDLE, S_FETCH, S_CHECK} state_type;

   state_type                       state_ff, state_in;
   logic                            op_ff, op_in;
   logic [7:0]                      client_ff, client_in;
   logic [31:0]                     now_ff, now_in;
   logic [CNT_W-1:0]                bound_ff, bound_in;   // entries to walk
   logic [CNT_W-1:0]                rd_ff, rd_in;         // walk position
   logic [CNT_W-1:0]                wr_ff, wr_in;         // compaction target
   logic [CNT_W-1:0]                count_ff, count_in;   // active clients
   logic [csta_pkg::TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   csta_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                            out_free;
   logic                            st_wr_en;
   logic [IDX_W-1:0]                st_wr_idx;
   csta_pkg::entry_type             st_wr_data;
   csta_pkg::entry_type             st_rd_data;
   csta_pkg::cmp_type               cmp;

   function automatic csta_pkg::rsp_type make_rsp(
      input logic [2:0] kind,
      input logic [7:0] addr,
      input logic [3:0] slot,
      input logic [4:0] count,
      input logic       last
   );
      csta_pkg::rsp_type r;
      r.kind         = kind;
      r.result_addr  = addr;
      r.slot         = slot;
      r.active_count = count;
      r.last         = last;
      return r;
   endfunction

   // Entry memory: one write port, one registered read at the walk position.
   csta_store #(
      .DEPTH (MAX_CLIENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_idx  (st_wr_idx),
      .wr_data (st_wr_data),
      .rd_idx  (rd_ff[IDX_W-1:0]),
      .rd_data (st_rd_data)
   );

   // Shared compare unit: address match and age-over-timeout test.
   csta_cmp u_cmp (
      .entry       (st_rd_data),
      .client_addr (client_ff),
      .now_ms      (now_ff),
      .timeout_ms  (timeout_ff),
      .result      (cmp)
   );

   // The result register may take a new value when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      client_in    = client_ff;
      now_in       = now_ff;
      bound_in     = bound_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      count_in     = count_ff;
      timeout_in   = csr_valid ? csr_data : timeout_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      st_wr_en     = 1'b0;
      st_wr_idx    = wr_ff[IDX_W-1:0];
      st_wr_data   = st_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            // Take a transaction and start the walk at the head of the table.
            if (req_valid) begin
               op_in     = req_data.op;
               client_in = req_data.client_addr;
               now_in    = req_data.now_ms;
               bound_in  = count_ff;
               rd_in     = '0;
               wr_in     = '0;
               state_in  = S_FETCH;
            end
         end

         S_FETCH: begin
            if (rd_ff != bound_ff) begin
               // Read address is rd_ff; data is ready in the next cycle.
               state_in = S_CHECK;
            end else if (out_free) begin
               // End of walk: close the item with its final result.
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == csta_pkg::OP_SWEEP) begin
                  rsp_data_in = make_rsp(csta_pkg::KIND_DONE, 8'd0, 4'd0,
                                         5'(count_ff), 1'b1);
               end else if (count_ff < MAX_COUNT) begin
                  // Append the unknown client at the end of the table.
                  st_wr_en    = 1'b1;
                  st_wr_idx   = count_ff[IDX_W-1:0];
                  st_wr_data  = '{addr: client_ff, seen: now_ff};
                  count_in    = count_ff + 1'b1;
                  rsp_data_in = make_rsp(csta_pkg::KIND_ADDED, client_ff,
                                         4'(count_ff), 5'(count_ff + 1'b1), 1'b1);
               end else begin
                  rsp_data_in = make_rsp(csta_pkg::KIND_FULL, client_ff, 4'd0,
                                         5'(count_ff), 1'b1);
               end
            end
         end

         S_CHECK: begin
            if (op_ff == csta_pkg::OP_MSG) begin
               if (!cmp.addr_hit) begin
                  rd_in    = rd_ff + 1'b1;
                  state_in = S_FETCH;
               end else if (out_free) begin
                  // Known client: refresh its timestamp in place.
                  st_wr_en     = 1'b1;
                  st_wr_idx    = rd_ff[IDX_W-1:0];
                  st_wr_data   = '{addr: client_ff, seen: now_ff};
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = make_rsp(csta_pkg::KIND_REFRESHED, client_ff,
                                          4'(rd_ff), 5'(count_ff), 1'b1);
                  state_in     = S_IDLE;
               end
            end else begin
               if (!cmp.stale) begin
                  // Keep: copy down to the compaction target.
                  st_wr_en = 1'b1;
                  wr_in    = wr_ff + 1'b1;
                  rd_in    = rd_ff + 1'b1;
                  state_in = S_FETCH;
               end else if (out_free) begin
                  // Drop: its slot is the number of entries kept so far.
                  count_in     = count_ff - 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = make_rsp(csta_pkg::KIND_REMOVED, st_rd_data.addr,
                                          4'(wr_ff), 5'(count_ff - 1'b1), 1'b0);
                  rd_in        = rd_ff + 1'b1;
                  state_in     = S_FETCH;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      client_ff   <= client_in;
      now_ff      <= now_in;
      bound_ff    <= bound_in;
      rd_ff       <= rd_in;
      wr_ff       <= wr_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         timeout_ff   <= csta_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// File: hw/rtl/csta_checker.sv
`include "assert_macros.svh"

module csta_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input csta_pkg::rsp_type                 rsp_data
);

   logic req_fire;
   logic closing_kind;

   assign req_fire     = req_valid && !req_stall;
   assign closing_kind = (rsp_data.kind != csta_pkg::KIND_REMOVED);

   // After reset: no result pending, ready for a transaction.
   `CSTA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall)

   // A stalled result holds.
   `CSTA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   // An accepted item keeps the block busy in the next cycle.
   `CSTA_ASSERT(a_busy_after_accept, clock, reset, req_fire |=> req_stall)

   // Only a removal leaves the item open; every other kind closes it.
   `CSTA_ASSERT(a_last_matches_kind, clock, reset, rsp_valid |-> (rsp_data.last == closing_kind))

endmodule

bind client_session_table_with_aging csta_checker u_csta_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
